>>> design/tsis_pkg.sv
// ----------------------------------------------------------------------------
// tsis_pkg: shared types and constants of the tar stream index scanner
// Transfer payloads, event codes, scan phases and fixed tar layout figures.
// ----------------------------------------------------------------------------
package tsis_pkg;

   // tar layout
   localparam int BLOCK_BYTES     = 512;
   localparam int POS_BITS        = 9;
   localparam int NAME_LEN        = 100;
   localparam int SIZE_START      = 124;
   localparam int SIZE_LEN        = 11;
   localparam int ZERO_RUN_END    = 2;

   // field widths
   localparam int SIZE_BITS       = 33;
   localparam int SKIP_BITS       = 25;
   localparam int OFFSET_OUT_BITS = 40;

   // event codes carried in event_kind
   localparam logic [2:0] EVT_NONE    = 3'd0;
   localparam logic [2:0] EVT_NAME    = 3'd1;
   localparam logic [2:0] EVT_HEADER  = 3'd2;
   localparam logic [2:0] EVT_END     = 3'd3;
   localparam logic [2:0] EVT_CORRUPT = 3'd4;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DATA   = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [2:0]                 event_kind;
      logic [7:0]                 name_char;
      logic [SIZE_BITS-1:0]       entry_size;
      logic [OFFSET_OUT_BITS-1:0] entry_offset;
   } rsp_type;

   typedef struct packed {
      phase_type           phase;
      logic [POS_BITS-1:0] position;
   } status_type;

endpackage

>>> design/tsis_scan_core.sv
// ----------------------------------------------------------------------------
// tsis_scan_core: per-byte header scanning and archive state
// Works out the result of one byte and updates block, size and skip state.
// ----------------------------------------------------------------------------
module tsis_scan_core #(
   parameter int OFFSET_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  tsis_pkg::req_type     req_data,
   output tsis_pkg::rsp_type     result,
   output tsis_pkg::status_type  status
);

   localparam int PosBits  = tsis_pkg::POS_BITS;
   localparam int SizeBits = tsis_pkg::SIZE_BITS;
   localparam int SkipBits = tsis_pkg::SKIP_BITS;
   localparam int OutBits  = tsis_pkg::OFFSET_OUT_BITS;

   logic [PosBits-1:0]     pos_ff,       pos_in;
   tsis_pkg::phase_type    phase_ff,     phase_in;
   logic [1:0]             zero_run_ff,  zero_run_in;
   logic                   zero_blk_ff,  zero_blk_in;
   logic                   name_done_ff, name_done_in;
   logic [SizeBits-1:0]    acc_ff,       acc_in;
   logic                   started_ff,   started_in;
   logic                   stopped_ff,   stopped_in;
   logic [SkipBits-1:0]    skip_ff,      skip_in;
   logic [OFFSET_BITS-1:0] stream_ff,    stream_in;

   logic [7:0]             byte_val;
   logic                   last_byte;
   logic                   in_name;
   logic                   in_size;
   logic                   zero_now;
   logic                   is_blank;
   logic                   is_digit;
   logic [1:0]             run_inc;
   logic [OFFSET_BITS-1:0] stream_inc;
   logic [SizeBits:0]      round_sum;
   logic [SkipBits-1:0]    blocks;

   // byte classification and block arithmetic
   assign byte_val   = req_data.byte_value;
   assign last_byte  = (pos_ff == PosBits'(tsis_pkg::BLOCK_BYTES - 1));
   assign in_name    = (pos_ff < PosBits'(tsis_pkg::NAME_LEN)) && !name_done_ff;
   assign in_size    = (pos_ff >= PosBits'(tsis_pkg::SIZE_START))
                    && (pos_ff < PosBits'(tsis_pkg::SIZE_START + tsis_pkg::SIZE_LEN))
                    && !stopped_ff;
   assign zero_now   = zero_blk_ff && (byte_val == 8'd0);
   assign is_blank   = (byte_val == 8'h20) || (byte_val inside {[8'h09:8'h0D]});
   assign is_digit   = byte_val inside {[8'h30:8'h37]};
   assign run_inc    = (zero_run_ff == 2'd3) ? zero_run_ff : zero_run_ff + 2'd1;
   assign stream_inc = stream_ff + 1'b1;
   assign round_sum  = {1'b0, acc_ff} + (SizeBits + 1)'(tsis_pkg::BLOCK_BYTES - 1);
   assign blocks     = round_sum[SizeBits:PosBits];

   assign status.phase    = phase_ff;
   assign status.position = pos_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= tsis_pkg::PHASE_HEADER;
         zero_run_ff  <= '0;
         zero_blk_ff  <= 1'b1;
         name_done_ff <= 1'b0;
         acc_ff       <= '0;
         started_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
         skip_ff      <= '0;
         stream_ff    <= '0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         zero_run_ff  <= zero_run_in;
         zero_blk_ff  <= zero_blk_in;
         name_done_ff <= name_done_in;
         acc_ff       <= acc_in;
         started_ff   <= started_in;
         stopped_ff   <= stopped_in;
         skip_ff      <= skip_in;
         stream_ff    <= stream_in;
      end
   end

   // next state and result of the byte on the input
   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      zero_run_in  = zero_run_ff;
      zero_blk_in  = zero_blk_ff;
      name_done_in = name_done_ff;
      acc_in       = acc_ff;
      started_in   = started_ff;
      stopped_in   = stopped_ff;
      skip_in      = skip_ff;
      stream_in    = stream_ff;
      result       = '0;
      result.event_kind = tsis_pkg::EVT_NONE;

      if (accept && phase_ff != tsis_pkg::PHASE_DONE) begin
         stream_in = stream_inc;

         case (phase_ff)
            tsis_pkg::PHASE_HEADER: begin
               zero_blk_in = zero_now;

               // name bytes up to the first null
               if (in_name) begin
                  if (byte_val == 8'd0) begin
                     name_done_in = 1'b1;
                  end else begin
                     result.event_kind = tsis_pkg::EVT_NAME;
                     result.name_char  = byte_val;
                  end
               end

               // octal size field
               if (in_size) begin
                  if (!started_ff && is_blank) begin
                     acc_in = acc_ff;
                  end else if (is_digit) begin
                     acc_in     = {acc_ff[SizeBits-4:0], byte_val[2:0]};
                     started_in = 1'b1;
                  end else begin
                     stopped_in = 1'b1;
                  end
               end

               // end of header block
               if (last_byte) begin
                  if (zero_now) begin
                     zero_run_in = run_inc;
                     if (run_inc >= 2'(tsis_pkg::ZERO_RUN_END)) begin
                        result.event_kind = tsis_pkg::EVT_END;
                        phase_in          = tsis_pkg::PHASE_DONE;
                     end
                  end else begin
                     zero_run_in         = '0;
                     result.event_kind   = tsis_pkg::EVT_HEADER;
                     result.entry_size   = acc_ff;
                     result.entry_offset = OutBits'(stream_inc);
                     skip_in             = blocks;
                     if (blocks != '0) begin
                        phase_in = tsis_pkg::PHASE_DATA;
                     end
                  end
                  pos_in       = '0;
                  zero_blk_in  = 1'b1;
                  name_done_in = 1'b0;
                  acc_in       = '0;
                  started_in   = 1'b0;
                  stopped_in   = 1'b0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end

            tsis_pkg::PHASE_DATA: begin
               // skip whole data blocks
               if (last_byte) begin
                  pos_in = '0;
                  if (skip_ff != '0) begin
                     skip_in = skip_ff - 1'b1;
                  end
                  if (skip_ff <= SkipBits'(1)) begin
                     phase_in = tsis_pkg::PHASE_HEADER;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end

            default: begin
               pos_in = pos_ff;
            end
         endcase

         // end of stream closes the scan
         if (req_data.end_of_stream) begin
            if (result.event_kind != tsis_pkg::EVT_END) begin
               result            = '0;
               result.event_kind = tsis_pkg::EVT_CORRUPT;
            end
            phase_in = tsis_pkg::PHASE_DONE;
         end
      end
   end

endmodule

>>> design/tsis_rsp_buffer.sv
// ----------------------------------------------------------------------------
// tsis_rsp_buffer: two-entry result register with skid stage
// Holds results so the input side keeps flowing while the receiver stalls.
// ----------------------------------------------------------------------------
module tsis_rsp_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tsis_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tsis_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   tsis_pkg::rsp_type main_data_ff,  main_data_in;
   tsis_pkg::rsp_type skid_data_ff,  skid_data_in;
   logic              push;
   logic              pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   // fill and drain of the two entries
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = in_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end
   end

endmodule

>>> design/tar_stream_index_scanner_unit.sv
// ----------------------------------------------------------------------------
// tar_stream_index_scanner_unit: streaming tar header scanner
// Takes one archive byte per transfer and gives one result per byte.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one archive byte and an end-of-stream flag per transfer.
//   rsp channel: one result per accepted byte: nothing, a file-name byte,
//   header complete (size and data offset), archive end, or archive corrupt.
//   Header bytes 0..99 pass name bytes until the first null; bytes 124..134
//   hold the octal size. Data blocks are skipped, two zero blocks end the
//   archive, and after the end every byte gives an empty result.
//   Each result is registered in the result buffer before it is shown.
//   Throughput: one byte per cycle while req_ready is high; the per-byte update of position, size
//   accumulator and skip count is a single registered step.
//   Stall: a two-entry result buffer keeps req_ready high while one result
//   waits; with both entries full req_ready drops until rsp_ready returns.
//   Reset: synchronous; the scanner restarts at the first header byte with
//   stream offset zero and the result buffer empty.
// ----------------------------------------------------------------------------
module tar_stream_index_scanner_unit #(
   parameter int OFFSET_BITS = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tsis_pkg::rsp_type rsp_data
);

   logic                 accept;
   tsis_pkg::rsp_type    core_result;
   tsis_pkg::status_type core_status;

   // input transfer
   assign accept = req_valid && req_ready;

   // scanning state and per-byte result
   tsis_scan_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .result   (core_result),
      .status   (core_status)
   );

   // result register and skid stage
   tsis_rsp_buffer u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_ready),
      .in_data   (core_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // input only stalls while both result entries are full
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // reset leaves the result buffer empty and ready
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid && req_ready)
      else $error("result buffer not empty after reset");

   // data blocks are stepped one byte per accepted transfer
   assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.end_of_stream && core_status.phase == tsis_pkg::PHASE_DATA
      && core_status.position != tsis_pkg::POS_BITS'(tsis_pkg::BLOCK_BYTES - 1)
      |=> core_status.position == $past(core_status.position) + 1'b1)
      else $error("data block position did not advance");

   // a name result always carries a non-null byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == tsis_pkg::EVT_NAME |-> rsp_data.name_char != 8'd0)
      else $error("null byte reported as name byte");

endmodule

>>> tb/tar_stream_index_scanner_unit_tb.sv
// ----------------------------------------------------------------------------
// tar_stream_index_scanner_unit_tb: self-checking bench of the tar scanner
// Streams whole tar archives into the scanner one byte per transfer. The
// archives hold long, empty and null-ended names, size fields with blanks,
// signs, stop characters and noise, data blocks to be skipped, lone zero
// blocks, and one randomly chosen way of ending the stream. A scoreboard
// works out the result of every accepted byte and checks each result
// transfer in order. Random idling on both sides until the closing part of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tar_stream_index_scanner_unit_tb;

   localparam int          OFFSET_BITS  = 40;
   localparam int          HALF_PERIOD  = 5;
   localparam int          DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 4000000;
   localparam int          ENTRY_COUNT  = 18;

   // characters used to build size fields
   localparam logic [7:0] ASCII_TAB     = 8'h09;
   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_PLUS    = 8'h2B;
   localparam logic [7:0] ASCII_MINUS   = 8'h2D;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_SEVEN   = 8'h37;
   localparam logic [7:0] ASCII_EIGHT   = 8'h38;
   localparam logic [7:0] ASCII_NINE    = 8'h39;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
   localparam logic [7:0] ASCII_CR      = 8'h0D;

   typedef enum int {
      SIZE_PADDED,
      SIZE_BLANKS,
      SIZE_STOPPED,
      SIZE_SIGNED,
      SIZE_NOISE
   } size_style_type;

   // scanner state mirror and queue of expected results
   class tar_scan_scoreboard;
      tsis_pkg::rsp_type                 expected_q[$];
      int                                errors;
      logic [tsis_pkg::POS_BITS-1:0]     blk_pos;
      tsis_pkg::phase_type               phase;
      logic [1:0]                        zero_run;
      bit                                blk_zero;
      bit                                name_done;
      logic [tsis_pkg::SIZE_BITS-1:0]    size_acc;
      bit                                digits_seen;
      bit                                digits_halted;
      logic [tsis_pkg::SKIP_BITS-1:0]    skip_left;
      logic [OFFSET_BITS-1:0]            stream_pos;

      function new();
         errors     = 0;
         phase      = tsis_pkg::PHASE_HEADER;
         zero_run   = '0;
         skip_left  = '0;
         stream_pos = '0;
         start_block();
      endfunction

      function void start_block();
         blk_pos       = '0;
         blk_zero      = 1'b1;
         name_done     = 1'b0;
         size_acc      = '0;
         digits_seen   = 1'b0;
         digits_halted = 1'b0;
      endfunction

      function bit is_blank(logic [7:0] b);
         return (b == ASCII_SPACE) || (b >= ASCII_TAB && b <= ASCII_CR);
      endfunction

      // work out the result of one accepted byte
      function void note_byte(tsis_pkg::req_type item);
         tsis_pkg::rsp_type res;
         logic [7:0]        b;
         logic [33:0]       rounded;
         bit                at_end;
         res = '0;
         b   = item.byte_value;
         if (phase == tsis_pkg::PHASE_DONE) begin
            expected_q.push_back(res);
            return;
         end
         stream_pos = stream_pos + 1'b1;
         at_end     = (blk_pos == tsis_pkg::BLOCK_BYTES - 1);
         if (phase == tsis_pkg::PHASE_HEADER) begin
            if (b != 8'd0)
               blk_zero = 1'b0;
            // name bytes up to the first null
            if (blk_pos < tsis_pkg::NAME_LEN && !name_done) begin
               if (b == 8'd0)
                  name_done = 1'b1;
               else begin
                  res.event_kind = tsis_pkg::EVT_NAME;
                  res.name_char  = b;
               end
            end
            // octal size field
            if (blk_pos >= tsis_pkg::SIZE_START
                && blk_pos < tsis_pkg::SIZE_START + tsis_pkg::SIZE_LEN
                && !digits_halted) begin
               if (b >= ASCII_ZERO && b <= ASCII_SEVEN) begin
                  size_acc    = {size_acc[tsis_pkg::SIZE_BITS-4:0], b[2:0]};
                  digits_seen = 1'b1;
               end else if (digits_seen || !is_blank(b))
                  digits_halted = 1'b1;
            end
            // block complete
            if (at_end) begin
               if (blk_zero) begin
                  if (zero_run != 2'd3)
                     zero_run = zero_run + 1'b1;
                  if (zero_run >= tsis_pkg::ZERO_RUN_END) begin
                     res.event_kind = tsis_pkg::EVT_END;
                     phase          = tsis_pkg::PHASE_DONE;
                  end
               end else begin
                  rounded          = {1'b0, size_acc} + (tsis_pkg::BLOCK_BYTES - 1);
                  zero_run         = '0;
                  res.event_kind   = tsis_pkg::EVT_HEADER;
                  res.entry_size   = size_acc;
                  res.entry_offset = stream_pos;
                  skip_left        = rounded[33:9];
                  if (skip_left != 0)
                     phase = tsis_pkg::PHASE_DATA;
               end
               start_block();
            end else
               blk_pos = blk_pos + 1'b1;
         end else begin
            // data blocks are passed over
            if (at_end) begin
               blk_pos = '0;
               if (skip_left != 0)
                  skip_left = skip_left - 1'b1;
               if (skip_left == 0)
                  phase = tsis_pkg::PHASE_HEADER;
            end else
               blk_pos = blk_pos + 1'b1;
         end
         if (item.end_of_stream) begin
            if (res.event_kind != tsis_pkg::EVT_END) begin
               res            = '0;
               res.event_kind = tsis_pkg::EVT_CORRUPT;
            end
            phase = tsis_pkg::PHASE_DONE;
         end
         expected_q.push_back(res);
      endfunction

      function void report_field(string field, logic [39:0] want, logic [39:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(tsis_pkg::rsp_type got);
         tsis_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, expected none, actual kind %0d",
                     $time, got.event_kind);
            return;
         end
         want = expected_q.pop_front();
         report_field("event_kind", 40'(want.event_kind), 40'(got.event_kind));
         report_field("name_char", 40'(want.name_char), 40'(got.name_char));
         report_field("entry_size", 40'(want.entry_size), 40'(got.entry_size));
         report_field("entry_offset", 40'(want.entry_offset), 40'(got.entry_offset));
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tsis_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tsis_pkg::rsp_type rsp_data;

   tar_scan_scoreboard sb;
   logic [7:0]  blk [0:tsis_pkg::BLOCK_BYTES-1];
   bit          idle_on = 1'b0;
   int          sink_hold = 0;
   int unsigned cycle_count = 0;

   tar_stream_index_scanner_unit #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (sink_hold > 1)
         sink_hold <= sink_hold - 1;
      else if (sink_hold == 1) begin
         sink_hold <= 0;
         rsp_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         sink_hold <= $urandom_range(1, 17);
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= 1'b1;
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one byte transfer, with an occasional gap before it
   task automatic send_byte(input logic [7:0] value, input logic last);
      tsis_pkg::req_type item;
      item.byte_value    = value;
      item.end_of_stream = last;
      if (idle_on && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(item);
   endtask

   // bytes 0 .. stop_at of the block buffer
   task automatic send_block(input int stop_at, input bit eos_last);
      if (!idle_on || $urandom_range(0, 7) == 0)
         idle_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i <= stop_at; i++)
         send_byte(blk[i], eos_last && i == stop_at);
   endtask

   task automatic send_quiet_block(input int stop_at, input bit eos_last);
      for (int i = 0; i <= stop_at; i++)
         send_byte(blk[i], eos_last && i == stop_at);
   endtask

   task automatic fill_block(input bit zeros);
      for (int i = 0; i < tsis_pkg::BLOCK_BYTES; i++)
         blk[i] = zeros ? 8'd0 : 8'($urandom_range(0, 255));
   endtask

   // hold off until every expected result has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] blank_code(int pick);
      return (pick < 5) ? ASCII_TAB + 8'(pick) : ASCII_SPACE;
   endfunction

   function automatic logic [7:0] stopper_code(int pick);
      case (pick)
         0:       return ASCII_EIGHT;
         1:       return ASCII_NINE;
         2:       return ASCII_PLUS;
         3:       return ASCII_MINUS;
         4:       return 8'd0;
         5:       return ASCII_SPACE;
         default: return ASCII_LOWER_Z;
      endcase
   endfunction

   // size field in one of several spellings
   task automatic write_size(input size_style_type style, input logic [32:0] value);
      int          pos;
      int          digits;
      logic [32:0] rest;
      pos    = tsis_pkg::SIZE_START;
      digits = 1;
      rest   = value >> 3;
      while (rest != 0) begin
         digits++;
         rest = rest >> 3;
      end
      case (style)
         SIZE_PADDED: digits = tsis_pkg::SIZE_LEN;
         SIZE_BLANKS: begin
            repeat ($urandom_range(1, 5)) begin
               blk[pos] = blank_code($urandom_range(0, 5));
               pos++;
            end
         end
         SIZE_SIGNED: begin
            blk[pos] = $urandom_range(0, 1) ? ASCII_PLUS : ASCII_MINUS;
            pos++;
         end
         SIZE_NOISE: begin
            // random bytes, cut short so the entry stays small
            blk[tsis_pkg::SIZE_START+4] = ASCII_LOWER_Z;
            return;
         end
         default: ;
      endcase
      for (int k = digits - 1; k >= 0; k--) begin
         blk[pos] = ASCII_ZERO + 8'(value[3*k +: 3]);
         pos++;
      end
      if (style == SIZE_BLANKS && pos < tsis_pkg::SIZE_START + tsis_pkg::SIZE_LEN)
         blk[pos] = $urandom_range(0, 1) ? ASCII_SPACE : 8'd0;
      if (style == SIZE_STOPPED && pos < tsis_pkg::SIZE_START + tsis_pkg::SIZE_LEN) begin
         blk[pos] = stopper_code($urandom_range(0, 6));
         for (int i = pos + 1; i < tsis_pkg::SIZE_START + tsis_pkg::SIZE_LEN; i++)
            blk[i] = ASCII_ZERO + 8'($urandom_range(0, 7));
      end
   endtask

   task automatic make_header(input int name_len, input size_style_type style,
                              input logic [32:0] value);
      fill_block(1'b0);
      for (int i = 0; i < name_len; i++)
         blk[i] = 8'($urandom_range(1, 255));
      if (name_len < tsis_pkg::NAME_LEN)
         blk[name_len] = 8'd0;
      // keeps the header non-zero
      blk[200] = 8'($urandom_range(1, 255));
      write_size(style, value);
   endtask

   // header already in the buffer, then the data blocks it announces
   task automatic send_entry();
      int blocks;
      send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      blocks = int'(sb.skip_left);
      repeat (blocks) begin
         fill_block($urandom_range(0, 5) == 0);
         send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      end
   endtask

   function automatic int pick_name_len();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return tsis_pkg::NAME_LEN;
         default: return $urandom_range(1, tsis_pkg::NAME_LEN - 1);
      endcase
   endfunction

   function automatic logic [32:0] pick_size();
      case ($urandom_range(0, 5))
         0:       return 33'd0;
         1:       return 33'(tsis_pkg::BLOCK_BYTES * $urandom_range(1, 2));
         2:       return 33'(tsis_pkg::BLOCK_BYTES * $urandom_range(1, 2) + 1);
         3:       return 33'(tsis_pkg::BLOCK_BYTES - 1);
         default: return 33'($urandom_range(1, 1600));
      endcase
   endfunction

   function automatic size_style_type pick_style();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)      return SIZE_PADDED;
      else if (r < 55) return SIZE_BLANKS;
      else if (r < 75) return SIZE_STOPPED;
      else if (r < 85) return SIZE_SIGNED;
      else             return SIZE_NOISE;
   endfunction

   initial begin
      bit prev_zero;
      int ending;
      int cut;
      sb        = new();
      prev_zero = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-length name with no null, size of zero
      make_header(tsis_pkg::NAME_LEN, SIZE_PADDED, 33'd0);
      send_entry();
      // empty name, every kind of leading blank before the digits
      make_header(0, SIZE_PADDED, 33'd0);
      for (int k = 0; k < 6; k++)
         blk[tsis_pkg::SIZE_START+k] = blank_code(k);
      blk[tsis_pkg::SIZE_START+6]  = ASCII_ZERO + 8'd1;
      blk[tsis_pkg::SIZE_START+7]  = ASCII_ZERO;
      blk[tsis_pkg::SIZE_START+8]  = ASCII_ZERO;
      blk[tsis_pkg::SIZE_START+9]  = ASCII_ZERO + 8'd1;
      blk[tsis_pkg::SIZE_START+10] = 8'd0;
      send_entry();
      // sign in front of the digits
      make_header(5, SIZE_SIGNED, 33'd511);
      send_entry();
      // non-octal digit after the first digit
      make_header(20, SIZE_STOPPED, 33'd7);
      blk[tsis_pkg::SIZE_START+1] = ASCII_EIGHT;
      send_entry();
      // lone zero block, then a header that is zero but for one byte
      fill_block(1'b1);
      send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      fill_block(1'b1);
      blk[300] = 8'd1;
      send_entry();
      // exactly one block of data, digit just past the size field
      make_header(tsis_pkg::NAME_LEN - 1, SIZE_PADDED, 33'(tsis_pkg::BLOCK_BYTES));
      blk[tsis_pkg::SIZE_START+tsis_pkg::SIZE_LEN] = ASCII_SEVEN;
      send_entry();
      // several data blocks, the first of them all zero
      make_header(1, SIZE_PADDED, 33'd2047);
      send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      fill_block(1'b1);
      send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      repeat (int'(sb.skip_left)) begin
         fill_block(1'b0);
         send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
      end
      wait_drained();

      // random archive entries
      for (int n = 0; n < ENTRY_COUNT; n++) begin
         if (!prev_zero && $urandom_range(0, 9) == 0) begin
            fill_block(1'b1);
            send_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
            prev_zero = 1'b1;
         end else begin
            make_header(pick_name_len(), pick_style(), pick_size());
            send_entry();
            prev_zero = 1'b0;
         end
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      // closing part of the stream, no idling
      idle_on <= 1'b0;
      ending = $urandom_range(0, 99);
      if (ending < 45) begin
         // two zero blocks end the archive
         fill_block(1'b1);
         send_quiet_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
         send_quiet_block(tsis_pkg::BLOCK_BYTES - 1, $urandom_range(0, 1) == 1);
      end else if (ending < 70) begin
         // largest size, stream cut inside its data
         make_header(pick_name_len(), SIZE_PADDED, {tsis_pkg::SIZE_BITS{1'b1}});
         send_quiet_block(tsis_pkg::BLOCK_BYTES - 1, 1'b0);
         fill_block(1'b0);
         send_quiet_block($urandom_range(0, tsis_pkg::BLOCK_BYTES - 1), 1'b1);
      end else begin
         // stream cut inside a header, sometimes on its last byte
         make_header(pick_name_len(), pick_style(), pick_size());
         cut = $urandom_range(0, 2) == 0 ? tsis_pkg::BLOCK_BYTES - 1
                                         : $urandom_range(0, tsis_pkg::BLOCK_BYTES - 2);
         send_quiet_block(cut, 1'b1);
      end
      // bytes after the end change nothing
      repeat (40)
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
design/tsis_pkg.sv
design/tsis_scan_core.sv
design/tsis_rsp_buffer.sv
design/tar_stream_index_scanner_unit.sv
tb/tar_stream_index_scanner_unit_tb.sv
